>>> rtl/qla_pkg.sv
// Package for the lane agent: widths, bin edges, register indexes, item kinds.
// Used by the controller, datapath, top level and bench; depends on nothing.
`timescale 1ns / 1ps
package qla_pkg;
  localparam int STATES_DEF = 605;
  localparam int VW_DEF = 32;
  localparam int ACTIONS = 3;
  localparam int FRAC_W = 17;
  localparam logic [16:0] FRAC_ONE = 17'd65536;
  localparam logic signed [8:0] RESIDUAL_STEP = 9'sd246;

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_GAMMA = 2'd1;
  localparam logic [1:0] REG_EPS = 2'd2;

  localparam logic KIND_SELECT = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic [1:0] ACT_NEUTRAL = 2'd1;

  typedef logic signed [15:0] edge_arr10_t [10];
  typedef logic signed [15:0] edge_arr4_t [4];
  localparam edge_arr10_t LAT_EDGES = '{-16'sd5120, -16'sd3277, -16'sd2048, -16'sd1024,
    -16'sd410, 16'sd410, 16'sd1024, 16'sd2048, 16'sd3277, 16'sd5120};
  localparam edge_arr10_t HEAD_EDGES = '{-16'sd1024, -16'sd614, -16'sd328, -16'sd164,
    -16'sd61, 16'sd61, 16'sd164, 16'sd328, 16'sd614, 16'sd1024};
  localparam edge_arr4_t PREV_EDGES = '{-16'sd819, -16'sd205, 16'sd205, 16'sd819};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic rd_sel;    // read address select: 0 item state row, 1 next state row
    logic rd_en;     // issue a row read
    logic cap_next;  // capture the largest entry of the row read as the next-state maximum
    logic cap_cur;   // capture the row read as the current row
    logic calc_tgt;  // form the target
    logic calc_new;  // form the new value and write it
    logic result;    // build the result item
  } qla_cmd_t;

  typedef struct packed {
    logic is_update;
    logic bad_index;
    logic terminated;
  } qla_stat_t;
endpackage

>>> rtl/qla_ctrl.sv
// Controller state machine for the lane agent.
// Depends on qla_pkg; drives qla_datapath through qla_cmd_t.
`timescale 1ns / 1ps
module qla_ctrl import qla_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_free,
  input  qla_stat_t stat,
  output logic      busy,
  output logic      out_load,
  output qla_cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_RDN, S_CAPN, S_RDC, S_CAPC, S_TGT, S_NEW, S_OUT
  } state_t;
  state_t state, state_next;

  always_comb begin
    cmd = '0;
    out_load = 1'b0;
    state_next = state;
    cmd.load = in_fire;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_RDN;
      S_RDN: begin
        // Next-state row first, so the current row stays in the read register.
        if (stat.is_update && !stat.bad_index && !stat.terminated) begin
          cmd.rd_en = 1'b1; cmd.rd_sel = 1'b1; state_next = S_CAPN;
        end else begin
          state_next = S_RDC;
        end
      end
      S_CAPN: begin cmd.cap_next = 1'b1; state_next = S_RDC; end
      S_RDC: begin cmd.rd_en = 1'b1; state_next = S_CAPC; end
      S_CAPC: begin
        cmd.cap_cur = 1'b1;
        state_next = (stat.is_update && !stat.bad_index) ? S_TGT : S_OUT;
      end
      S_TGT: begin cmd.calc_tgt = 1'b1; state_next = S_NEW; end
      S_NEW: begin cmd.calc_new = 1'b1; state_next = S_OUT; end
      S_OUT: begin
        if (out_free) begin
          cmd.result = 1'b1; out_load = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

>>> rtl/qla_datapath.sv
// Datapath for the lane agent: quantizer, value table memory, update arithmetic.
// Depends on qla_pkg; sequenced by qla_ctrl.
`timescale 1ns / 1ps
module qla_datapath import qla_pkg::*; #(
  parameter int STATES = STATES_DEF,
  parameter int VALUE_WIDTH = VW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  qla_cmd_t           cmd,
  output qla_stat_t          stat,
  input  logic [16:0]        alpha,
  input  logic [16:0]        gamma,
  input  logic [16:0]        eps,
  input  logic               in_kind,
  input  logic signed [15:0] lat,
  input  logic signed [15:0] head,
  input  logic signed [15:0] prev,
  input  logic               allow_exp,
  input  logic [15:0]        draw,
  input  logic [1:0]         rnd_act,
  input  logic [9:0]         s_idx,
  input  logic [1:0]         t_act,
  input  logic signed [31:0] reward,
  input  logic [9:0]         ns_idx,
  input  logic               term,
  output logic [9:0]         r_state,
  output logic [1:0]         r_action,
  output logic signed [8:0]  r_resid,
  output logic signed [31:0] r_value,
  output logic               r_err
);
  localparam int SW = $clog2(STATES);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = VW + FRAC_W;
  localparam int TW = ((VW > 32) ? VW : 32) + 2;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // Held item
  logic kind, aexp, term_q, bad;
  logic [15:0] draw_q;
  logic [1:0] ra_q, ta_q;
  logic [SW-1:0] st_q, ns_q;
  logic signed [31:0] rew_q;
  logic [9:0] qst;

  // Value table, one row of three entries per state, cleared by a sweep.
  logic [3*VW-1:0] mem [STATES];
  logic [3*VW-1:0] rd_data;
  logic [SW-1:0] clr_addr;
  logic clr_busy;
  logic signed [VW-1:0] nrow_max, cur_v, tgt, new_v;
  logic [3*VW-1:0] cur_row;
  logic [3*VW-1:0] wr_row;

  function automatic logic [3:0] count_le10(logic signed [15:0] v, edge_arr10_t e);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 10; i++) if (e[i] <= v) c = c + 4'd1;
    return c;
  endfunction

  function automatic logic [2:0] count_le4(logic signed [15:0] v);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < 4; i++) if (PREV_EDGES[i] <= v) c = c + 3'd1;
    return c;
  endfunction

  function automatic logic [16:0] fclamp(logic [16:0] r);
    return (r > FRAC_ONE) ? FRAC_ONE : r;
  endfunction

  logic [3:0] lb, hb;
  logic [2:0] pb;
  assign lb = count_le10(lat, LAT_EDGES);
  assign hb = count_le10(head, HEAD_EDGES);
  assign pb = count_le4(prev);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_kind;
      aexp <= allow_exp;
      draw_q <= draw;
      ra_q <= rnd_act;
      ta_q <= t_act;
      term_q <= term;
      rew_q <= reward;
      st_q <= SW'(s_idx);
      ns_q <= SW'(ns_idx);
      qst <= 10'((({6'd0, lb} * 10'd11) + {6'd0, hb}) * 10'd5 + {7'd0, pb});
      bad <= (in_kind == KIND_UPDATE) &&
             ((32'(s_idx) >= STATES) || (32'(ns_idx) >= STATES) || (t_act == 2'd3));
    end
  end

  assign stat.is_update = kind;
  assign stat.bad_index = bad;
  assign stat.terminated = term_q;

  logic [SW-1:0] rd_addr;
  always_comb begin
    if (cmd.rd_sel) rd_addr = ns_q;
    else if (kind == KIND_UPDATE) rd_addr = st_q;
    else rd_addr = SW'(qst);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (32'(clr_addr) == STATES - 1) clr_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) mem[clr_addr] <= '0;
    else if (cmd.calc_new) mem[st_q] <= wr_row;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  output_clear_guard: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !cmd.load) else $error("item taken during table clear");

  // Row entries
  logic signed [VW-1:0] e0, e1, e2;
  assign e0 = rd_data[VW-1:0];
  assign e1 = rd_data[2*VW-1:VW];
  assign e2 = rd_data[3*VW-1:2*VW];

  always_ff @(posedge clk) begin
    if (cmd.cap_next) begin
      nrow_max <= e0;
      if (e1 > e0 && e1 >= e2) nrow_max <= e1;
      else if (e2 > e0 && e2 > e1) nrow_max <= e2;
    end
    if (cmd.cap_cur) begin
      cur_row <= rd_data;
      unique case (ta_q)
        2'd0: cur_v <= e0;
        2'd1: cur_v <= e1;
        default: cur_v <= e2;
      endcase
    end
  end

  // Scale a magnitude by a Q1.16 fraction, rounded half away from zero.
  function automatic logic [VW:0] scale(logic [VW:0] m, logic [16:0] b);
    logic [PW:0] p;
    p = {{FRAC_W{1'b0}}, m} * {{(VW+1){1'b0}}, b} + (PW+1)'(32768);
    return p[VW+16:16];
  endfunction

  // Target: reward + gamma * max (reward alone when terminated), saturated; sum wide enough for both terms.
  logic [VW:0] mmag, gmag;
  logic signed [TW-1:0] gsig, tsum;
  logic signed [TW-1:0] rew_x;
  assign mmag = nrow_max[VW-1] ? (VW+1)'(-$signed({nrow_max[VW-1], nrow_max}))
                               : {1'b0, nrow_max};
  assign gmag = scale(mmag, fclamp(gamma));
  assign gsig = nrow_max[VW-1] ? TW'(-$signed({1'b0, gmag})) : TW'($signed({1'b0, gmag}));
  assign rew_x = TW'(rew_q);
  assign tsum = term_q ? rew_x : rew_x + gsig;

  always_ff @(posedge clk) begin
    if (cmd.calc_tgt) begin
      if (tsum > TW'(VMAX)) tgt <= VMAX;
      else if (tsum < TW'(VMIN)) tgt <= VMIN;
      else tgt <= tsum[VW-1:0];
    end
  end

  // New value: cur +/- alpha * |tgt - cur|; stays between cur and tgt.
  logic signed [VW:0] diff;
  logic [VW:0] dmag, step;
  logic signed [VW+1:0] nsum;
  assign diff = $signed({tgt[VW-1], tgt}) - $signed({cur_v[VW-1], cur_v});
  assign dmag = diff[VW] ? (VW+1)'(-diff) : diff;
  assign step = scale(dmag, fclamp(alpha));
  assign nsum = diff[VW] ? $signed({cur_v[VW-1], cur_v[VW-1], cur_v}) - $signed({1'b0, step})
                         : $signed({cur_v[VW-1], cur_v[VW-1], cur_v}) + $signed({1'b0, step});
  assign new_v = nsum[VW-1:0];

  always_comb begin
    wr_row = cur_row;
    unique case (ta_q)
      2'd0: wr_row[VW-1:0] = new_v;
      2'd1: wr_row[2*VW-1:VW] = new_v;
      default: wr_row[3*VW-1:2*VW] = new_v;
    endcase
  end

  logic signed [VW-1:0] upd_v;
  always_ff @(posedge clk) begin
    if (cmd.calc_new) upd_v <= new_v;
  end

  // Greedy choice over the current row; ties with action 1 go to neutral, a 0/2 tie goes to action 0.
  logic [1:0] greedy;
  always_comb begin
    greedy = ACT_NEUTRAL;
    if (e0 > e1 && e0 >= e2) greedy = 2'd0;
    else if (e2 > e1 && e2 > e0) greedy = 2'd2;
  end
  logic [1:0] grd_q;
  always_ff @(posedge clk) begin
    if (cmd.cap_cur) grd_q <= greedy;
  end

  logic explore;
  assign explore = aexp && ({1'b0, draw_q} < eps);

  always_comb begin
    r_state = '0; r_action = '0; r_resid = '0; r_value = '0; r_err = 1'b0;
    if (kind == KIND_SELECT) begin
      r_state = qst;
      if (explore && ra_q != 2'd3) r_action = ra_q;
      else r_action = grd_q;
      r_err = explore && (ra_q == 2'd3);
      unique case (r_action)
        2'd0: r_resid = -RESIDUAL_STEP;
        2'd2: r_resid = RESIDUAL_STEP;
        default: r_resid = '0;
      endcase
    end else if (bad) begin
      r_err = 1'b1;
    end else begin
      r_value = 32'(upd_v);
    end
  end
endmodule

>>> rtl/q_learning_lane_agent_top.sv
// Top level of the tabular Q-learning lane agent.
// One item at a time: a select reads its state row; an update reads the
// next-state row (skipped when terminated or rejected) and its own row, then,
// unless rejected, forms the target and the new value and writes the row back.
// Reset: synchronous; a sweep clears the table, one row per cycle,
// with no item accepted until it ends; registers return to their defaults.
`timescale 1ns / 1ps
module q_learning_lane_agent_top import qla_pkg::*; #(
  parameter int STATES = STATES_DEF,
  parameter int VALUE_WIDTH = VW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: lateral_error[15:0], heading_error[31:16], previous_steering[47:32],
  // explore_en[48], explore_draw[64:49], random_action[66:65],
  // src_state[76:67], taken_action[78:77], reward[110:79],
  // dst_state[120:111], terminated[121], zero fill to 128
  input  logic [127:0] s_tdata,
  input  logic         s_tuser,   // tuser: item kind (0 select, 1 update)
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: observed_state[9:0], chosen_action[11:10], steering_residual[20:12],
  // updated_value[52:21], error_code[53], zero fill to 56
  output logic [55:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  logic [16:0] alpha, gamma, eps;
  qla_cmd_t cmd;
  qla_stat_t stat;
  logic busy, out_load, in_fire, out_free, clr_done;
  logic [9:0] r_state;
  logic [1:0] r_action;
  logic signed [8:0] r_resid;
  logic signed [31:0] r_value;
  logic r_err;

  // Config registers; always ready, a write takes effect at once, so send
  // writes only while no item is in flight.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 17'd6554; gamma <= 17'd62259; eps <= 17'd6554;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ALPHA: alpha <= cfg_data;
        REG_GAMMA: gamma <= cfg_data;
        REG_EPS: eps <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off input until the table clear sweep finishes.
  logic [$clog2(STATES+1)-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (!clr_done) clr_cnt <= clr_cnt + 1'b1;
  end
  assign clr_done = (32'(clr_cnt) >= STATES);

  assign s_tready = clr_done && !busy;
  assign in_fire = s_tvalid && s_tready;
  // Output register frees when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  qla_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .stat, .busy, .out_load, .cmd
  );

  qla_datapath #(.STATES(STATES), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .cmd, .stat, .alpha, .gamma, .eps,
    .in_kind(s_tuser),
    .lat(s_tdata[15:0]), .head(s_tdata[31:16]), .prev(s_tdata[47:32]),
    .allow_exp(s_tdata[48]), .draw(s_tdata[64:49]), .rnd_act(s_tdata[66:65]),
    .s_idx(s_tdata[76:67]), .t_act(s_tdata[78:77]), .reward(s_tdata[110:79]),
    .ns_idx(s_tdata[120:111]), .term(s_tdata[121]),
    .r_state, .r_action, .r_resid, .r_value, .r_err
  );

  // Output register: hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {2'b00, r_err, r_value, r_resid, r_action, r_state};
  end
endmodule

>>> rtl/qla_checker.sv
// Port-level checker for the lane agent, bound to the top level.
// Depends on q_learning_lane_agent_top ports only.
`timescale 1ns / 1ps
module qla_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);
  a_no_take_while_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second item taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("result dropped");
  a_resid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:10] != 2'd3)) else $error("bad action code");
  a_err_val: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[53]) |-> (m_tdata[52:21] == 32'd0)) else $error("value on error");
endmodule

bind q_learning_lane_agent_top qla_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

>>> dv/q_learning_lane_agent_top_tb.sv
// Self-checking bench for the Q-learning lane agent: a scoreboard class predicts
// each result from its own copy of the value table and the fraction registers.
// Depends on qla_pkg and q_learning_lane_agent_top.
`timescale 1ns / 1ps

class lane_agent_scoreboard;
  longint unsigned q_table [605*3];
  logic [16:0] alpha, gamma, eps;
  logic [55:0] pending [$];
  int errors;

  function void clear();
    foreach (q_table[i]) q_table[i] = 0;
    alpha = 17'd6554;
    gamma = 17'd62259;
    eps = 17'd6554;
    pending.delete();
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [16:0] val);
    if (idx == qla_pkg::REG_ALPHA) alpha = val;
    else if (idx == qla_pkg::REG_GAMMA) gamma = val;
    else if (idx == qla_pkg::REG_EPS) eps = val;
  endfunction

  static function int bin_of(logic signed [15:0] v, int kind);
    int c;
    c = 0;
    for (int i = 0; i < 10; i++) begin
      if (kind == 0 && i < 10 && qla_pkg::LAT_EDGES[i] <= v) c++;
      if (kind == 1 && qla_pkg::HEAD_EDGES[i] <= v) c++;
      if (kind == 2 && i < 4 && qla_pkg::PREV_EDGES[i] <= v) c++;
    end
    return c;
  endfunction

  // Scale a magnitude by a Q1.16 fraction, rounding half away from zero.
  static function longint signed frac_mul(longint signed m, logic [16:0] f);
    longint signed b;
    b = (f > 17'd65536) ? 65536 : f;
    return (m * b + 32768) >>> 16;
  endfunction

  static function longint signed signed_mul(longint signed v, logic [16:0] f);
    return (v < 0) ? -frac_mul(-v, f) : frac_mul(v, f);
  endfunction

  static function longint signed clamp32(longint signed x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function int greedy_action(int s);
    int best;
    best = 1;
    for (int a = 0; a < 3; a++)
      if (longint'(q_table[s*3+a]) > longint'(q_table[s*3+best])) best = a;
    return best;
  endfunction

  // Note an accepted input item and queue its predicted result.
  function void note_item(logic kind, logic [121:0] d);
    logic [55:0] r;
    int s, ns, a, act;
    logic err;
    longint signed cur, tgt, mx, nv;
    r = '0;
    err = 0;
    if (kind == qla_pkg::KIND_SELECT) begin
      s = (bin_of(d[15:0], 0) * 11 + bin_of(d[31:16], 1)) * 5 + bin_of(d[47:32], 2);
      act = greedy_action(s);
      if (d[48] && {1'b0, d[64:49]} < eps) begin
        if (d[66:65] < 3) act = int'(d[66:65]);
        else err = 1;
      end
      r[9:0] = 10'(s);
      r[11:10] = 2'(act);
      r[20:12] = 9'((act - 1) * 246);
      r[53] = err;
    end else begin
      s = int'(d[76:67]);
      a = int'(d[78:77]);
      ns = int'(d[120:111]);
      if (s >= 605 || a >= 3 || ns >= 605) begin
        r[53] = 1;
      end else begin
        cur = longint'(q_table[s*3+a]);
        tgt = longint'($signed(d[110:79]));
        if (!d[121]) begin
          mx = longint'(q_table[ns*3]);
          for (int k = 1; k < 3; k++)
            if (longint'(q_table[ns*3+k]) > mx) mx = longint'(q_table[ns*3+k]);
          tgt = tgt + signed_mul(mx, gamma);
        end
        tgt = clamp32(tgt);
        nv = (tgt >= cur) ? cur + frac_mul(tgt - cur, alpha)
                          : cur - frac_mul(cur - tgt, alpha);
        nv = clamp32(nv);
        q_table[s*3+a] = nv;
        r[52:21] = nv[31:0];
      end
    end
    pending.push_back(r);
  endfunction

  task automatic report(string what, logic [55:0] got, logic [55:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Check a result against the oldest expectation, field by field.
  task automatic check_result(logic [55:0] got);
    logic [55:0] w;
    if (pending.size() == 0) begin
      report("unexpected result", got, '0);
      return;
    end
    w = pending.pop_front();
    if (got[9:0] != w[9:0]) report("observed_state", got, w);
    if (got[11:10] != w[11:10]) report("chosen_action", got, w);
    if (got[20:12] != w[20:12]) report("steering_residual", got, w);
    if (got[52:21] != w[52:21]) report("updated_value", got, w);
    if (got[53] != w[53]) report("error_code", got, w);
  endtask
endclass

module q_learning_lane_agent_top_tb;
  import qla_pkg::*;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [127:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [55:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [16:0] cfg_data;

  lane_agent_scoreboard board;
  int idle_cycles;
  int rx_hold, rx_gap;
  bit rx_pause;

  q_learning_lane_agent_top u_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: stall for a random gap after each result unless paused, check every accepted one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      rx_hold <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (rx_pause) begin
        m_tready <= 1'b1;
        rx_hold <= 0;
      end else if (rx_hold != 0) begin
        m_tready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (m_tvalid && m_tready) begin
        rx_gap = gap_len();
        m_tready <= (rx_gap == 0);
        rx_hold <= (rx_gap == 0) ? 0 : rx_gap - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with nothing accepted.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // After a random gap, send one item, hold it until it is accepted, then drop valid.
  task automatic send_item(logic kind, logic [121:0] d);
    int g;
    g = gap_len();
    repeat (g) @(posedge clk);
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {6'd0, d};
    do @(posedge clk); while (!s_tready);
    board.note_item(kind, d);
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Wait for every expected result to drain, then let the block settle.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [121:0] select_item(logic [15:0] lat, logic [15:0] head,
                                               logic [15:0] prev, logic ex,
                                               logic [15:0] draw, logic [1:0] ra);
    logic [121:0] d;
    d = 122'({$urandom, $urandom, $urandom, $urandom});
    d[15:0] = lat;
    d[31:16] = head;
    d[47:32] = prev;
    d[48] = ex;
    d[64:49] = draw;
    d[66:65] = ra;
    return d;
  endfunction

  function automatic logic [121:0] update_item(logic [9:0] s, logic [1:0] a, logic [31:0] rw,
                                               logic [9:0] ns, logic term);
    logic [121:0] d;
    d = 122'({$urandom, $urandom, $urandom, $urandom});
    d[76:67] = s;
    d[78:77] = a;
    d[110:79] = rw;
    d[120:111] = ns;
    d[121] = term;
    return d;
  endfunction

  // Random select item: values near bin edges half the time.
  task automatic rand_select();
    logic [15:0] v [3];
    for (int i = 0; i < 3; i++)
      v[i] = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 12000)) - 16'd6000 : 16'($urandom);
    send_item(KIND_SELECT, select_item(v[0], v[1], v[2], 1'($urandom_range(0, 1)),
                                       16'($urandom), 2'($urandom_range(0, 3))));
  endtask

  // Random update: mostly valid indices in a small hot set so rows build up.
  task automatic rand_update();
    logic [9:0] s, ns;
    logic [1:0] a;
    s = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15) * 37);
    ns = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15) * 37);
    a = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    send_item(KIND_UPDATE, update_item(s, a, $urandom, ns, $urandom_range(0, 3) == 0));
  endtask

  initial begin
    board = new();
    board.clear();
    rst = 1;
    rx_pause = 0;
    s_tvalid = 0;
    s_tuser = 0;
    s_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: bin extremes, exploration cases, update extremes and errors.
    send_item(KIND_SELECT, select_item(16'h8000, 16'h8000, 16'h8000, 1'b0, 16'd0, 2'd0));
    send_item(KIND_SELECT, select_item(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 16'd0, 2'd0));
    send_item(KIND_SELECT, select_item(16'd5120, 16'd61, -16'sd205, 1'b1, 16'd0, 2'd0));
    send_item(KIND_SELECT, select_item(16'd5119, 16'd60, -16'sd206, 1'b1, 16'd0, 2'd3));
    send_item(KIND_SELECT, select_item(16'd0, 16'd0, 16'd0, 1'b1, 16'hffff, 2'd2));
    send_item(KIND_UPDATE, update_item(10'd0, 2'd0, 32'h7fffffff, 10'd0, 1'b0));
    send_item(KIND_UPDATE, update_item(10'd604, 2'd2, 32'h80000000, 10'd604, 1'b1));
    send_item(KIND_UPDATE, update_item(10'd605, 2'd0, 32'd100, 10'd0, 1'b0));
    send_item(KIND_UPDATE, update_item(10'd0, 2'd3, 32'd100, 10'd0, 1'b0));
    send_item(KIND_UPDATE, update_item(10'd0, 2'd0, 32'd100, 10'h3ff, 1'b1));
    send_item(KIND_UPDATE, update_item(10'd1, 2'd1, 32'h0001_0000, 10'd0, 1'b0));
    send_item(KIND_SELECT, select_item(-16'sd5120, -16'sd1024, -16'sd819, 1'b0, 16'd0, 2'd0));
    send_item(KIND_SELECT, select_item(16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 2'd0));
    drain();

    // Phases over register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(REG_ALPHA, 17'd65536); write_cfg(REG_GAMMA, 17'd0);
                 write_cfg(REG_EPS, 17'd0); end
        1: begin write_cfg(REG_ALPHA, 17'd1); write_cfg(REG_GAMMA, 17'd65536);
                 write_cfg(REG_EPS, 17'd65536); end
        2: begin write_cfg(REG_ALPHA, 17'h1ffff); write_cfg(REG_GAMMA, 17'h1ffff);
                 write_cfg(REG_EPS, 17'h1ffff); end
        3: begin write_cfg(REG_ALPHA, 17'd0); write_cfg(2'd3, 17'd77); end
        default: begin write_cfg(REG_ALPHA, 17'($urandom_range(1, 65536)));
                 write_cfg(REG_GAMMA, 17'($urandom_range(0, 65536)));
                 write_cfg(REG_EPS, 17'($urandom_range(0, 65536))); end
      endcase
      for (int i = 0; i < 165; i++) begin
        if ($urandom_range(0, 1)) rand_select();
        else rand_update();
        if (ph == 4 && i == 80) begin
          rx_pause = 1;
          drain();
          rx_pause = 0;
        end
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

>>> sim.f
rtl/qla_pkg.sv
rtl/qla_ctrl.sv
rtl/qla_datapath.sv
rtl/q_learning_lane_agent_top.sv
rtl/qla_checker.sv
dv/q_learning_lane_agent_top_tb.sv
